[hdl/nmbp_pkg.sv]
// nmbp_pkg: shared types, widths and constants of the normal-mapped Blinn-Phong shader
// no dependencies; used by nmbp_cfg_if, nmbp_unit3, nmbp_atten and the top module
`default_nettype none

package nmbp_pkg;

	// configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t REG_LIGHT_X = 3'd0;
	localparam cfg_idx_t REG_LIGHT_Y = 3'd1;
	localparam cfg_idx_t REG_LIGHT_Z = 3'd2;
	localparam cfg_idx_t REG_EYE_X   = 3'd3;
	localparam cfg_idx_t REG_EYE_Y   = 3'd4;
	localparam cfg_idx_t REG_EYE_Z   = 3'd5;

	// register reset values, signed Q4.12
	localparam logic signed [15:0] LIGHT_X_RST = 16'sd1229;
	localparam logic signed [15:0] LIGHT_Y_RST = -16'sd410;
	localparam logic signed [15:0] LIGHT_Z_RST = 16'sd1229;
	localparam logic signed [15:0] EYE_X_RST   = -16'sd3686;
	localparam logic signed [15:0] EYE_Y_RST   = 16'sd819;
	localparam logic signed [15:0] EYE_Z_RST   = 16'sd3277;

	// normalizer widths
	localparam int VEC_W  = 18;	// signed input vector component
	localparam int MAG_W  = 17;	// component magnitude
	localparam int SQ_W   = 33;	// one squared component
	localparam int SUM_W  = 34;	// sum of squares
	localparam int LEN_W  = 29;	// length with 12 extra fraction bits
	localparam int NUM_W  = 44;	// dividend of one component
	localparam int QUO_W  = 15;	// component quotient
	localparam int UNIT_W = 16;	// signed Q2.14 result

	// pipeline depths of the two parallel paths
	localparam int UNIT3_LAT = 48;
	localparam int ATTEN_LAT = 40;
	localparam int ATT_PAD   = UNIT3_LAT - ATTEN_LAT;

	// shading constants
	localparam logic [14:0] ONE_Q14  = 15'd16384;
	localparam logic [15:0] ONE_Q15  = 16'd32768;
	localparam logic [13:0] AMB_K    = 14'd13107;	// 0.2 in Q16
	localparam logic [7:0]  SPEC_K   = 8'd204;	// 0.2 * 255 * 4
	localparam logic [12:0] ATT_K1   = 13'd5898;	// 0.09 in Q16
	localparam logic [11:0] ATT_K2   = 12'd2097;	// 0.032 in Q16

	typedef logic signed [UNIT_W-1:0] unit_t;

	typedef struct packed {
		logic [10:0] x;
		logic [10:0] y;
		logic [15:0] depth;
	} pix_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		pix_t pix;
		rgb_t tex;
	} frag_pass_t;

	// side data riding with the halfway normalizer
	typedef struct packed {
		frag_pass_t        pass;
		logic [2:0][15:0]  n;
		logic [2:0][29:0]  pnl;
		logic [15:0]       att;
	} h_side_t;

	// side data of the specular power stages
	typedef struct packed {
		frag_pass_t  pass;
		logic [14:0] diff;
		logic [15:0] att;
	} tail_t;

	// clamped Q2.14 dot product from a Q4.28 sum
	function automatic logic [14:0] dot_clamp(input logic signed [31:0] d);
		logic signed [31:0] t;
		t = d >>> 14;
		if (d <= 32'sd0)
			return 15'd0;
		else if (t > 32'sd16384)
			return ONE_Q14;
		else
			return t[14:0];
	endfunction

	// rounded Q2.14 square
	function automatic logic [14:0] sqr_round(input logic [14:0] v);
		logic [30:0] p;
		p = v * v + 31'd8192;
		return p[28:14];
	endfunction

endpackage

`default_nettype wire

[hdl/nmbp_if.sv]
// nmbp interfaces: fragment input, shaded output and configuration write channels
// depends on nmbp_pkg for the register index type
`default_nettype none

interface nmbp_frag_in_if;
	logic               valid;
	logic               ready;
	logic [10:0]        pix_x;
	logic [10:0]        pix_y;
	logic [15:0]        depth;
	logic signed [15:0] frag_x;
	logic signed [15:0] frag_y;
	logic signed [15:0] frag_z;
	logic [7:0]         tex_r;
	logic [7:0]         tex_g;
	logic [7:0]         tex_b;
	logic [7:0]         nrm_r;
	logic [7:0]         nrm_g;
	logic [7:0]         nrm_b;

	modport source (output valid, pix_x, pix_y, depth, frag_x, frag_y, frag_z,
		tex_r, tex_g, tex_b, nrm_r, nrm_g, nrm_b, input ready);
	modport sink (input valid, pix_x, pix_y, depth, frag_x, frag_y, frag_z,
		tex_r, tex_g, tex_b, nrm_r, nrm_g, nrm_b, output ready);
endinterface

interface nmbp_frag_out_if;
	logic        valid;
	logic        ready;
	logic [10:0] out_x;
	logic [10:0] out_y;
	logic [15:0] out_depth;
	logic [7:0]  shade_r;
	logic [7:0]  shade_g;
	logic [7:0]  shade_b;

	modport source (output valid, out_x, out_y, out_depth, shade_r, shade_g, shade_b,
		input ready);
	modport sink (input valid, out_x, out_y, out_depth, shade_r, shade_g, shade_b,
		output ready);
endinterface

interface nmbp_cfg_if;
	logic                valid;
	logic                ready;
	nmbp_pkg::cfg_idx_t  index;
	logic [15:0]         data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/nmbp_sqrt.sv]
// nmbp_sqrt: pipelined integer square root, one result bit per stage
// no package dependency; used by nmbp_unit3 and nmbp_atten
`default_nettype none

module nmbp_sqrt #(
	parameter int IW = 34,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [IW-1:0]   in_val,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [IW/2-1:0] out_root,
	output logic [SW-1:0]   out_side
);

	localparam int RW = IW / 2;

	logic          vld_s  [1:RW];
	logic [IW-1:0] rem_s  [1:RW];
	logic [RW-1:0] root_s [1:RW];
	logic [SW-1:0] side_s [1:RW];

	for (genvar i = 0; i < RW; i++) begin : g_stg
		localparam int B = RW - 1 - i;
		logic          p_vld;
		logic [IW-1:0] p_rem;
		logic [RW-1:0] p_root;
		logic [SW-1:0] p_side;
		logic [IW:0]   trial;
		logic          take;

		if (i == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_rem  = in_val;
			assign p_root = '0;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_s[i];
			assign p_rem  = rem_s[i];
			assign p_root = root_s[i];
			assign p_side = side_s[i];
		end

		// try setting root bit B: (2R + 2^B) * 2^B against the remainder
		assign trial = ({{(IW + 1 - RW){1'b0}}, p_root} << (B + 1))
			| ((IW + 1)'(1) << (2 * B));
		assign take = {1'b0, p_rem} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i + 1] <= 1'b0;
			else if (en)
				vld_s[i + 1] <= p_vld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i + 1]  <= take ? IW'({1'b0, p_rem} - trial) : p_rem;
				root_s[i + 1] <= take ? (p_root | (RW'(1) << B)) : p_root;
				side_s[i + 1] <= p_side;
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign out_root  = root_s[RW];
	assign out_side  = side_s[RW];

endmodule

`default_nettype wire

[hdl/nmbp_div.sv]
// nmbp_div: pipelined restoring divider, one quotient bit per stage
// no package dependency; used by nmbp_unit3 and nmbp_atten
`default_nettype none

module nmbp_div #(
	parameter int NW = 44,
	parameter int DW = 29,
	parameter int QW = 15,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quot,
	output logic [SW-1:0] out_side
);

	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic          vld_s  [1:QW];
	logic [NW-1:0] rem_s  [1:QW];
	logic [DW-1:0] den_s  [1:QW];
	logic [QW-1:0] quot_s [1:QW];
	logic [SW-1:0] side_s [1:QW];

	for (genvar i = 0; i < QW; i++) begin : g_stg
		localparam int K = QW - 1 - i;
		logic          p_vld;
		logic [NW-1:0] p_rem;
		logic [DW-1:0] p_den;
		logic [QW-1:0] p_quot;
		logic [SW-1:0] p_side;
		logic [CW-1:0] shd;
		logic          take;

		if (i == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_rem  = in_num;
			assign p_den  = in_den;
			assign p_quot = '0;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_s[i];
			assign p_rem  = rem_s[i];
			assign p_den  = den_s[i];
			assign p_quot = quot_s[i];
			assign p_side = side_s[i];
		end

		// subtract the shifted divisor where it fits
		assign shd  = CW'(p_den) << K;
		assign take = CW'(p_rem) >= shd;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i + 1] <= 1'b0;
			else if (en)
				vld_s[i + 1] <= p_vld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i + 1]  <= take ? NW'(CW'(p_rem) - shd) : p_rem;
				den_s[i + 1]  <= p_den;
				quot_s[i + 1] <= take ? (p_quot | (QW'(1) << K)) : p_quot;
				side_s[i + 1] <= p_side;
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_quot  = quot_s[QW];
	assign out_side  = side_s[QW];

endmodule

`default_nettype wire

[hdl/nmbp_unit3.sv]
// nmbp_unit3: pipelined 3-vector normalizer to signed Q2.14, with side data carried along
// depends on nmbp_pkg, nmbp_sqrt and nmbp_div
`default_nettype none

module nmbp_unit3 #(
	parameter int SW = 1
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         en,
	input  logic                                         in_valid,
	input  logic [2:0][nmbp_pkg::VEC_W-1:0]              in_vec,
	input  logic [SW-1:0]                                in_side,
	output logic                                         out_valid,
	output logic [2:0][nmbp_pkg::UNIT_W-1:0]             out_unit,
	output logic [SW-1:0]                                out_side
);

	localparam int MW  = nmbp_pkg::MAG_W;
	localparam int SQB = SW + 1 + 3 + 3 * MW;
	localparam int DVB = SW + 2;

	// squares and magnitudes
	logic signed [2*nmbp_pkg::VEC_W-1:0] sq_full [3];
	logic signed [nmbp_pkg::VEC_W-1:0]   abs_v   [3];

	logic                              vld_s1;
	logic [2:0][nmbp_pkg::SQ_W-1:0]    sq_s1;
	logic [2:0][MW-1:0]                mag_s1;
	logic [2:0]                        neg_s1;
	logic [SW-1:0]                     side_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_full[i] = $signed(in_vec[i]) * $signed(in_vec[i]);
			abs_v[i]   = in_vec[i][nmbp_pkg::VEC_W-1] ? -$signed(in_vec[i]) : $signed(in_vec[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i]  <= sq_full[i][nmbp_pkg::SQ_W-1:0];
				mag_s1[i] <= abs_v[i][MW-1:0];
				neg_s1[i] <= in_vec[i][nmbp_pkg::VEC_W-1];
			end
			side_s1 <= in_side;
		end
	end

	// sum of squares
	logic                          vld_s2;
	logic [nmbp_pkg::SUM_W-1:0]    sum_s2;
	logic [2:0][MW-1:0]            mag_s2;
	logic [2:0]                    neg_s2;
	logic [SW-1:0]                 side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= nmbp_pkg::SUM_W'(sq_s1[0]) + nmbp_pkg::SUM_W'(sq_s1[1])
				+ nmbp_pkg::SUM_W'(sq_s1[2]);
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
		end
	end

	// length with 12 extra fraction bits
	logic                          sq_vld;
	logic [nmbp_pkg::LEN_W-1:0]    len;
	logic [SQB-1:0]                sq_side;

	nmbp_sqrt #(
		.IW (2 * nmbp_pkg::LEN_W),
		.SW (SQB)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_val    ({sum_s2, 24'd0}),
		.in_side   ({side_s2, (sum_s2 == '0), neg_s2, mag_s2}),
		.out_valid (sq_vld),
		.out_root  (len),
		.out_side  (sq_side)
	);

	// rounded dividends
	logic [2:0][MW-1:0] sq_mag;
	assign sq_mag = sq_side[3*MW-1:0];

	logic                              vld_s3;
	logic [2:0][nmbp_pkg::NUM_W-1:0]   num_s3;
	logic [nmbp_pkg::LEN_W-1:0]        len_s3;
	logic [2:0]                        neg_s3;
	logic                              zero_s3;
	logic [SW-1:0]                     side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= sq_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				num_s3[i] <= nmbp_pkg::NUM_W'({sq_mag[i], 26'd0})
					+ nmbp_pkg::NUM_W'(len >> 1);
			len_s3  <= len;
			neg_s3  <= sq_side[3*MW+2:3*MW];
			zero_s3 <= sq_side[3*MW+3];
			side_s3 <= sq_side[SQB-1:3*MW+4];
		end
	end

	// one divider lane per component
	logic                           dv_vld;
	logic [2:0][nmbp_pkg::QUO_W-1:0] quot;
	logic [DVB-1:0]                 dv_side0;
	logic                           dv_neg1;
	logic                           dv_neg2;

	nmbp_div #(
		.NW (nmbp_pkg::NUM_W),
		.DW (nmbp_pkg::LEN_W),
		.QW (nmbp_pkg::QUO_W),
		.SW (DVB)
	) u_div0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_num    (num_s3[0]),
		.in_den    (len_s3),
		.in_side   ({side_s3, zero_s3, neg_s3[0]}),
		.out_valid (dv_vld),
		.out_quot  (quot[0]),
		.out_side  (dv_side0)
	);

	nmbp_div #(
		.NW (nmbp_pkg::NUM_W),
		.DW (nmbp_pkg::LEN_W),
		.QW (nmbp_pkg::QUO_W),
		.SW (1)
	) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_num    (num_s3[1]),
		.in_den    (len_s3),
		.in_side   (neg_s3[1]),
		.out_valid (),
		.out_quot  (quot[1]),
		.out_side  (dv_neg1)
	);

	nmbp_div #(
		.NW (nmbp_pkg::NUM_W),
		.DW (nmbp_pkg::LEN_W),
		.QW (nmbp_pkg::QUO_W),
		.SW (1)
	) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_num    (num_s3[2]),
		.in_den    (len_s3),
		.in_side   (neg_s3[2]),
		.out_valid (),
		.out_quot  (quot[2]),
		.out_side  (dv_neg2)
	);

	// clamp, sign and zero vector
	logic [2:0] dv_neg;
	logic [2:0][nmbp_pkg::QUO_W-1:0] qc;
	assign dv_neg = {dv_neg2, dv_neg1, dv_side0[0]};

	always_comb begin
		for (int i = 0; i < 3; i++)
			qc[i] = (quot[i] > nmbp_pkg::ONE_Q14) ? nmbp_pkg::ONE_Q14 : quot[i];
	end

	logic                               vld_s4;
	logic [2:0][nmbp_pkg::UNIT_W-1:0]   unit_s4;
	logic [SW-1:0]                      side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_side0[1])
					unit_s4[i] <= '0;
				else if (dv_neg[i])
					unit_s4[i] <= -nmbp_pkg::UNIT_W'(qc[i]);
				else
					unit_s4[i] <= nmbp_pkg::UNIT_W'(qc[i]);
			end
			side_s4 <= dv_side0[DVB-1:2];
		end
	end

	assign out_valid = vld_s4;
	assign out_unit  = unit_s4;
	assign out_side  = side_s4;

endmodule

`default_nettype wire

[hdl/nmbp_atten.sv]
// nmbp_atten: pipelined distance attenuation 1/(1 + 0.09d + 0.032d^2) in Q1.15
// depends on nmbp_pkg, nmbp_sqrt and nmbp_div
`default_nettype none

module nmbp_atten (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [2:0][16:0] in_tol,
	output logic             out_valid,
	output logic [15:0]      out_att
);

	// squared components
	logic signed [33:0] sq_full [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			sq_full[i] = $signed(in_tol[i]) * $signed(in_tol[i]);
	end

	logic             vld_s1;
	logic [2:0][31:0] sq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s1[i] <= sq_full[i][31:0];
		end
	end

	// squared distance
	logic        vld_s2;
	logic [33:0] sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en)
			sum_s2 <= 34'(sq_s1[0]) + 34'(sq_s1[1]) + 34'(sq_s1[2]);
	end

	// distance, unsigned Q5.12
	logic        dist_vld;
	logic [16:0] distance;

	nmbp_sqrt #(
		.IW (34),
		.SW (1)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_val    (sum_s2),
		.in_side   (1'b0),
		.out_valid (dist_vld),
		.out_root  (distance),
		.out_side  ()
	);

	// linear term and distance squared
	logic [29:0] lin_full;
	logic [33:0] dsq_full;
	assign lin_full = distance * nmbp_pkg::ATT_K1;
	assign dsq_full = distance * distance;

	logic        vld_s3;
	logic [29:0] lin_s3;
	logic [33:0] dsq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= dist_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s3 <= lin_full;
			dsq_s3 <= dsq_full;
		end
	end

	// quadratic term
	logic [45:0] quad_full;
	assign quad_full = dsq_s3 * nmbp_pkg::ATT_K2;

	logic        vld_s4;
	logic [29:0] lin_s4;
	logic [45:0] quad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s4  <= lin_s3;
			quad_s4 <= quad_full;
		end
	end

	// denominator in Q.28
	logic        vld_s5;
	logic [34:0] den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else if (en)
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en)
			den_s5 <= (35'd1 << 28) + 35'(lin_s4) + 35'(quad_s4[45:12]);
	end

	// rounded dividend
	logic        vld_s6;
	logic [34:0] den_s6;
	logic [43:0] num_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else if (en)
			vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6 <= den_s5;
			num_s6 <= (44'd1 << 43) + 44'(den_s5 >> 1);
		end
	end

	logic        dv_vld;
	logic [15:0] quot;

	nmbp_div #(
		.NW (44),
		.DW (35),
		.QW (16),
		.SW (1)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.in_num    (num_s6),
		.in_den    (den_s6),
		.in_side   (1'b0),
		.out_valid (dv_vld),
		.out_quot  (quot),
		.out_side  ()
	);

	// clamp to 1.0
	logic        vld_s7;
	logic [15:0] att_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s7 <= 1'b0;
		else if (en)
			vld_s7 <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (en)
			att_s7 <= (quot > nmbp_pkg::ONE_Q15) ? nmbp_pkg::ONE_Q15 : quot;
	end

	assign out_valid = vld_s7;
	assign out_att   = att_s7;

endmodule

`default_nettype wire

[hdl/normal_map_blinn_phong_shade_top.sv]
// normal_map_blinn_phong_shade_top: per-fragment Blinn-Phong shader with normal map
// depends on nmbp_pkg, nmbp_if, nmbp_unit3, nmbp_atten (and through them nmbp_sqrt, nmbp_div)
//
//   channel    modport   carries
//   frag_in    sink      pix_x, pix_y, depth, frag_x/y/z, tex_r/g/b, nrm_r/g/b
//   frag_out   source    out_x, out_y, out_depth, shade_r/g/b
//   cfg        sink      index (0..5 light x/y/z, eye x/y/z), data; always ready
//
// one fragment per cycle unless the output stalls; the path runs through two normalizers
// in series (29-stage square root and 15-stage divider each)
// the whole pipeline advances whenever the output register is empty or being taken,
// so a stall freezes every stage in place and frag_in.ready follows it
// arst_n clears all valid bits and loads the register reset values
`default_nettype none

module normal_map_blinn_phong_shade_top (
	input  logic                    clk,
	input  logic                    arst_n,
	nmbp_frag_in_if.sink            frag_in,
	nmbp_frag_out_if.source         frag_out,
	nmbp_cfg_if.sink                cfg
);

	// pipeline advance
	logic en;
	logic out_vld_q;
	assign en = !out_vld_q || frag_out.ready;
	assign frag_in.ready = en;
	assign cfg.ready = 1'b1;

	// light and eye registers
	logic signed [15:0] light_q [3];
	logic signed [15:0] eye_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q[0] <= nmbp_pkg::LIGHT_X_RST;
			light_q[1] <= nmbp_pkg::LIGHT_Y_RST;
			light_q[2] <= nmbp_pkg::LIGHT_Z_RST;
			eye_q[0]   <= nmbp_pkg::EYE_X_RST;
			eye_q[1]   <= nmbp_pkg::EYE_Y_RST;
			eye_q[2]   <= nmbp_pkg::EYE_Z_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				nmbp_pkg::REG_LIGHT_X: light_q[0] <= cfg.data;
				nmbp_pkg::REG_LIGHT_Y: light_q[1] <= cfg.data;
				nmbp_pkg::REG_LIGHT_Z: light_q[2] <= cfg.data;
				nmbp_pkg::REG_EYE_X:   eye_q[0]   <= cfg.data;
				nmbp_pkg::REG_EYE_Y:   eye_q[1]   <= cfg.data;
				nmbp_pkg::REG_EYE_Z:   eye_q[2]   <= cfg.data;
				default: ;
			endcase
		end
	end

	// stage 1: light and eye offsets, unpacked normal
	logic signed [15:0] frag_v [3];
	logic [7:0]         nrm_c [3];
	assign frag_v[0] = frag_in.frag_x;
	assign frag_v[1] = frag_in.frag_y;
	assign frag_v[2] = frag_in.frag_z;
	assign nrm_c[0]  = frag_in.nrm_r;
	assign nrm_c[1]  = frag_in.nrm_g;
	assign nrm_c[2]  = frag_in.nrm_b;

	logic                 vld_s1;
	logic [2:0][16:0]     tol_s1;
	logic [2:0][16:0]     toe_s1;
	logic [2:0][8:0]      nv_s1;
	nmbp_pkg::frag_pass_t pass_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= frag_in.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tol_s1[i] <= 17'($signed({light_q[i][15], light_q[i]})
					- $signed({frag_v[i][15], frag_v[i]}));
				toe_s1[i] <= 17'($signed({eye_q[i][15], eye_q[i]})
					- $signed({frag_v[i][15], frag_v[i]}));
				nv_s1[i]  <= 9'($signed({1'b0, nrm_c[i], 1'b0}) - 11'sd255);
			end
			pass_s1.pix.x     <= frag_in.pix_x;
			pass_s1.pix.y     <= frag_in.pix_y;
			pass_s1.pix.depth <= frag_in.depth;
			pass_s1.tex.r     <= frag_in.tex_r;
			pass_s1.tex.g     <= frag_in.tex_g;
			pass_s1.tex.b     <= frag_in.tex_b;
		end
	end

	// normalizer inputs, sign-extended
	logic [2:0][nmbp_pkg::VEC_W-1:0] nv_ext, tol_ext, toe_ext;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nv_ext[i]  = {{(nmbp_pkg::VEC_W - 9){nv_s1[i][8]}}, nv_s1[i]};
			tol_ext[i] = {{(nmbp_pkg::VEC_W - 17){tol_s1[i][16]}}, tol_s1[i]};
			toe_ext[i] = {{(nmbp_pkg::VEC_W - 17){toe_s1[i][16]}}, toe_s1[i]};
		end
	end

	// normal, light and view directions
	logic                             n_vld;
	logic [2:0][nmbp_pkg::UNIT_W-1:0] n_u, l_u, e_u;
	nmbp_pkg::frag_pass_t             n_pass;

	nmbp_unit3 #(
		.SW ($bits(nmbp_pkg::frag_pass_t))
	) u_unit_n (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_vec    (nv_ext),
		.in_side   (pass_s1),
		.out_valid (n_vld),
		.out_unit  (n_u),
		.out_side  (n_pass)
	);

	nmbp_unit3 #(
		.SW (1)
	) u_unit_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_vec    (tol_ext),
		.in_side   (1'b0),
		.out_valid (),
		.out_unit  (l_u),
		.out_side  ()
	);

	nmbp_unit3 #(
		.SW (1)
	) u_unit_e (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_vec    (toe_ext),
		.in_side   (1'b0),
		.out_valid (),
		.out_unit  (e_u),
		.out_side  ()
	);

	// attenuation, padded to the normalizer depth
	logic [15:0] att_raw;

	nmbp_atten u_atten (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_tol    (tol_s1),
		.out_valid (),
		.out_att   (att_raw)
	);

	logic [15:0] att_pad_s [nmbp_pkg::ATT_PAD];

	always_ff @(posedge clk) begin
		if (en) begin
			att_pad_s[0] <= att_raw;
			for (int j = 1; j < nmbp_pkg::ATT_PAD; j++)
				att_pad_s[j] <= att_pad_s[j - 1];
		end
	end

	// stage 2: halfway sum and n.l products
	logic signed [31:0] pnl_full [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			pnl_full[i] = $signed(n_u[i]) * $signed(l_u[i]);
	end

	logic                            vld_s2;
	logic [2:0][nmbp_pkg::VEC_W-1:0] hv_s2;
	nmbp_pkg::h_side_t               hs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= n_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				hv_s2[i]     <= nmbp_pkg::VEC_W'($signed(l_u[i]))
					+ nmbp_pkg::VEC_W'($signed(e_u[i]));
				hs_s2.pnl[i] <= pnl_full[i][29:0];
			end
			hs_s2.n    <= n_u;
			hs_s2.pass <= n_pass;
			hs_s2.att  <= att_pad_s[nmbp_pkg::ATT_PAD - 1];
		end
	end

	// halfway direction
	logic                             h_vld;
	logic [2:0][nmbp_pkg::UNIT_W-1:0] h_u;
	nmbp_pkg::h_side_t                hs;

	nmbp_unit3 #(
		.SW ($bits(nmbp_pkg::h_side_t))
	) u_unit_h (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_vec    (hv_s2),
		.in_side   (hs_s2),
		.out_valid (h_vld),
		.out_unit  (h_u),
		.out_side  (hs)
	);

	// stage 3: n.h products, diffuse factor
	logic signed [31:0] pnh_full [3];
	logic signed [31:0] nl_sum;

	always_comb begin
		for (int i = 0; i < 3; i++)
			pnh_full[i] = $signed(hs.n[i]) * $signed(h_u[i]);
		nl_sum = 32'($signed(hs.pnl[0])) + 32'($signed(hs.pnl[1]))
			+ 32'($signed(hs.pnl[2]));
	end

	logic             vld_s3;
	logic [2:0][29:0] pnh_s3;
	nmbp_pkg::tail_t  tl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= h_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				pnh_s3[i] <= pnh_full[i][29:0];
			tl_s3.diff <= nmbp_pkg::dot_clamp(nl_sum);
			tl_s3.pass <= hs.pass;
			tl_s3.att  <= hs.att;
		end
	end

	// stage 4: specular base
	logic signed [31:0] nh_sum;
	assign nh_sum = 32'($signed(pnh_s3[0])) + 32'($signed(pnh_s3[1]))
		+ 32'($signed(pnh_s3[2]));

	logic            vld_s4;
	logic [14:0]     spec_s4;
	nmbp_pkg::tail_t tl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s4 <= nmbp_pkg::dot_clamp(nh_sum);
			tl_s4   <= tl_s3;
		end
	end

	// stages 5 to 8: power 16 by four rounded squarings
	logic            pw_vld_s  [4];
	logic [14:0]     pw_spec_s [4];
	nmbp_pkg::tail_t pw_tl_s   [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 4; j++)
				pw_vld_s[j] <= 1'b0;
		end else if (en) begin
			pw_vld_s[0] <= vld_s4;
			for (int j = 1; j < 4; j++)
				pw_vld_s[j] <= pw_vld_s[j - 1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pw_spec_s[0] <= nmbp_pkg::sqr_round(spec_s4);
			pw_tl_s[0]   <= tl_s4;
			for (int j = 1; j < 4; j++) begin
				pw_spec_s[j] <= nmbp_pkg::sqr_round(pw_spec_s[j - 1]);
				pw_tl_s[j]   <= pw_tl_s[j - 1];
			end
		end
	end

	// stage 9: per-channel term products
	nmbp_pkg::tail_t tl8;
	logic [7:0]      tex8 [3];
	assign tl8     = pw_tl_s[3];
	assign tex8[0] = tl8.pass.tex.r;
	assign tex8[1] = tl8.pass.tex.g;
	assign tex8[2] = tl8.pass.tex.b;

	logic [21:0] amb_full [3];
	logic [22:0] dif_full [3];
	logic [22:0] spc_full;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			amb_full[i] = tex8[i] * nmbp_pkg::AMB_K;
			dif_full[i] = tex8[i] * tl8.diff;
		end
		spc_full = pw_spec_s[3] * nmbp_pkg::SPEC_K;
	end

	logic        vld_s9;
	logic [21:0] amb_s9 [3];
	logic [22:0] dif_s9 [3];
	logic [22:0] spc_s9;
	logic [15:0] att_s9;
	nmbp_pkg::pix_t pix_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s9 <= 1'b0;
		else if (en)
			vld_s9 <= pw_vld_s[3];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				amb_s9[i] <= amb_full[i];
				dif_s9[i] <= dif_full[i];
			end
			spc_s9 <= spc_full;
			att_s9 <= tl8.att;
			pix_s9 <= tl8.pass.pix;
		end
	end

	// stage 10: color sums in Q16
	logic           vld_s10;
	logic [24:0]    sum_s10 [3];
	logic [15:0]    att_s10;
	nmbp_pkg::pix_t pix_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s10 <= 1'b0;
		else if (en)
			vld_s10 <= vld_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sum_s10[i] <= 25'(amb_s9[i]) + {1'b0, dif_s9[i], 1'b0} + 25'(spc_s9);
			att_s10 <= att_s9;
			pix_s10 <= pix_s9;
		end
	end

	// stage 11: attenuated sums
	logic [40:0] lit_full [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			lit_full[i] = sum_s10[i] * att_s10;
	end

	logic           vld_s11;
	logic [40:0]    lit_s11 [3];
	nmbp_pkg::pix_t pix_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s11 <= 1'b0;
		else if (en)
			vld_s11 <= vld_s10;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				lit_s11[i] <= lit_full[i];
			pix_s11 <= pix_s10;
		end
	end

	// output register: truncate and clamp to 255
	logic [7:0]     shade_q [3];
	nmbp_pkg::pix_t pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= vld_s11;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				shade_q[i] <= (lit_s11[i][40:31] > 10'd255) ? 8'd255 : lit_s11[i][38:31];
			pix_q <= pix_s11;
		end
	end

	assign frag_out.valid     = out_vld_q;
	assign frag_out.out_x     = pix_q.x;
	assign frag_out.out_y     = pix_q.y;
	assign frag_out.out_depth = pix_q.depth;
	assign frag_out.shade_r   = shade_q[0];
	assign frag_out.shade_g   = shade_q[1];
	assign frag_out.shade_b   = shade_q[2];

endmodule

`default_nettype wire
